[src/chacha20_pkg.sv]
package chacha20_pkg;

	localparam int ROUND_COUNT_DEF = 20;
	localparam int BYTE_W          = 8;
	localparam int WORD_W          = 32;
	localparam int REG_W           = 64;
	localparam int WORD_CNT        = 16;
	localparam int ADDR_W          = 6;
	localparam int REG_IDX_W       = 3;

	localparam logic [REG_IDX_W-1:0] REG_KEY0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY1  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY2  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY3  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NONCE = 3'd4;

	// ARX step codes inside one quarter-round
	localparam logic [1:0] STEP_AB16 = 2'd0;
	localparam logic [1:0] STEP_CD12 = 2'd1;
	localparam logic [1:0] STEP_AB8  = 2'd2;
	localparam logic [1:0] STEP_CD7  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       idle;
		logic       round_en;
		logic [1:0] step;
		logic       diag;
		logic       last_qr;
		logic       add_en;
		logic       add_last;
		logic [3:0] add_idx;
		logic       emit;
	} seq_ctl_t;

	// "expand 32-byte k"
	function automatic logic [WORD_W-1:0] sigma_word(input logic [1:0] idx);
		logic [WORD_W-1:0] w;
		unique case (idx)
			2'd0: w = 32'h6170_7865;
			2'd1: w = 32'h3320_646e;
			2'd2: w = 32'h7962_2d32;
			2'd3: w = 32'h6b20_6574;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[src/chacha20_stream_cipher.sv]
// Channel   | Signals                                   | Dir | Transaction
// ----------+-------------------------------------------+-----+------------------------------
// config    | psel penable pwrite paddr pwdata prdata   | in  | 64-bit register at 8*index
// input     | in_valid in_stall data_in first_byte      | in  | one byte plus message flags
//           | last_byte                                 |     |
// output    | out_valid out_stall data_out last_out     | out | one transformed byte
//
// Bytes inside a keystream block: accepted directly, result in the next cycle.
// A byte at block position 0 (or with first_byte) makes a new block on the
// shared ARX unit: one add/xor/rotate per cycle over ceil(R/2) double rounds,
// then sixteen feed-forward adds, and the result is registered once the
// output is free; in_stall is high meanwhile.
// Reset clears keys, nonce, block counter, byte position and control state.
// A stalled output holds the next transaction off; one byte can wait there.
module chacha20_stream_cipher #(
	parameter int ROUND_COUNT = chacha20_pkg::ROUND_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [chacha20_pkg::ADDR_W-1:0]      paddr,
	input  logic [chacha20_pkg::REG_W-1:0]       pwdata,
	output logic [chacha20_pkg::REG_W-1:0]       prdata,
	output logic                                 pready,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [chacha20_pkg::BYTE_W-1:0]      data_in,
	input  logic                                 first_byte,
	input  logic                                 last_byte,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [chacha20_pkg::BYTE_W-1:0]      data_out,
	output logic                                 last_out
);

	localparam int WW = chacha20_pkg::WORD_W;

	logic [3:0][chacha20_pkg::REG_W-1:0] key_w;
	logic [chacha20_pkg::REG_W-1:0]      nonce_w;
	chacha20_pkg::seq_ctl_t              ctl;

	logic [chacha20_pkg::REG_W-1:0]  counter_q;   // next block number
	logic [5:0]                      pos_q;       // next keystream byte
	logic [chacha20_pkg::BYTE_W-1:0] data_q;      // byte waiting for its block
	logic                            last_q;
	logic [WW-1:0]                   work_q [chacha20_pkg::WORD_CNT];

	logic                            out_valid_q;
	logic [chacha20_pkg::BYTE_W-1:0] out_data_q;
	logic                            out_last_q;

	logic in_acc, need_blk, start, direct, out_free, emit_fire;
	logic [chacha20_pkg::REG_W-1:0]  ctr_sel;
	logic [WW-1:0] init_w  [chacha20_pkg::WORD_CNT];
	logic [WW-1:0] upd     [chacha20_pkg::WORD_CNT];
	logic [WW-1:0] rnd_nxt [chacha20_pkg::WORD_CNT];
	logic [1:0]    rot_k   [4];
	logic [WW-1:0] arx_x, arx_y, arx_z, arx_sum, arx_mix;
	logic [WW-1:0] ks_word;
	logic [chacha20_pkg::BYTE_W-1:0] ks_byte;

	chacha20_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key_w),
		.nonce   (nonce_w)
	);

	// Handshake. A new block is needed at position 0 or on a message start.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !ctl.idle || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign need_blk  = first_byte || (pos_q == '0);
	assign start     = in_acc && need_blk;
	assign direct    = in_acc && !need_blk;
	assign emit_fire = ctl.emit && out_free;

	chacha20_seq #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// Block input state; a message start uses counter zero right away.
	assign ctr_sel = (in_acc && first_byte) ? '0 : counter_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]       = chacha20_pkg::sigma_word(2'(i));
			init_w[4 + 2*i] = key_w[i][31:0];
			init_w[5 + 2*i] = key_w[i][63:32];
		end
		init_w[12] = ctr_sel[31:0];
		init_w[13] = ctr_sel[63:32];
		init_w[14] = nonce_w[31:0];
		init_w[15] = nonce_w[63:32];
	end

	// The working state is four rows of four words. A quarter-round always
	// works on the word at slot 0 of each row (a, b, c, d = words 0, 4, 8, 12);
	// rows are rotated after each quarter-round to bring the next column or
	// diagonal into slot 0.
	always_comb begin
		if (ctl.add_en) begin
			arx_x = work_q[0];
			arx_y = init_w[ctl.add_idx];
			arx_z = work_q[12];
		end else if (!ctl.step[0]) begin
			arx_x = work_q[0];
			arx_y = work_q[4];
			arx_z = work_q[12];
		end else begin
			arx_x = work_q[8];
			arx_y = work_q[12];
			arx_z = work_q[4];
		end
	end

	chacha20_arx u_arx (
		.step (ctl.step),
		.x    (arx_x),
		.y    (arx_y),
		.z    (arx_z),
		.sum  (arx_sum),
		.mix  (arx_mix)
	);

	// Row rotation after a quarter-round: step to the next column/diagonal,
	// and at the end of a phase switch to diagonal order or back to columns.
	always_comb begin
		if (!ctl.last_qr) begin
			rot_k[0] = 2'd1; rot_k[1] = 2'd1; rot_k[2] = 2'd1; rot_k[3] = 2'd1;
		end else if (!ctl.diag) begin
			rot_k[0] = 2'd1; rot_k[1] = 2'd2; rot_k[2] = 2'd3; rot_k[3] = 2'd0;
		end else begin
			rot_k[0] = 2'd1; rot_k[1] = 2'd0; rot_k[2] = 2'd3; rot_k[3] = 2'd2;
		end
	end

	always_comb begin
		logic [1:0] src;
		src = '0;
		for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
			upd[i] = work_q[i];
		if (!ctl.step[0]) begin
			upd[0]  = arx_sum;
			upd[12] = arx_mix;
		end else begin
			upd[8] = arx_sum;
			upd[4] = arx_mix;
		end
		for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
			rnd_nxt[i] = upd[i];
		if (ctl.step == chacha20_pkg::STEP_CD7) begin
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < 4; j++) begin
					src = 2'(j) + rot_k[r];
					rnd_nxt[4*r + j] = upd[{2'(r), src}];
				end
			end
		end
	end

	// Feed-forward: the state shifts down one word per add and the sum enters
	// at the top, so after sixteen adds the rows hold the keystream block.
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
				work_q[i] <= init_w[i];
		end else if (ctl.round_en) begin
			for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
				work_q[i] <= rnd_nxt[i];
		end else if (ctl.add_en) begin
			for (int i = 0; i < chacha20_pkg::WORD_CNT - 1; i++)
				work_q[i] <= work_q[i + 1];
			work_q[chacha20_pkg::WORD_CNT - 1] <= arx_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= data_in;
			last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pos_q     <= '0;
		end else begin
			if (start && first_byte)
				counter_q <= '0;
			else if (ctl.add_last)
				counter_q <= counter_q + 64'd1;

			if (start && first_byte)
				pos_q <= '0;
			else if (direct)
				pos_q <= last_byte ? '0 : pos_q + 6'd1;
			else if (emit_fire)
				pos_q <= last_q ? '0 : pos_q + 6'd1;
		end
	end

	assign ks_word = work_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: chacha20_pkg::BYTE_W];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (direct || emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (direct) begin
			out_data_q <= data_in ^ ks_byte;
			out_last_q <= last_byte;
		end else if (emit_fire) begin
			out_data_q <= data_q ^ ks_byte;
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = out_data_q;
	assign last_out  = out_last_q;

	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && first_byte) |=> (pos_q == '0 && counter_q == '0))
		else $error("message start did not clear position and counter");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(direct || emit_fire))
		else $error("output transaction without a source");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_last |=> (counter_q == $past(counter_q) + 64'd1))
		else $error("block counter did not advance once per block");

endmodule

[src/chacha20_arx.sv]
// Shared add / xor / rotate unit.
module chacha20_arx (
	input  logic [1:0]                        step,
	input  logic [chacha20_pkg::WORD_W-1:0]   x,
	input  logic [chacha20_pkg::WORD_W-1:0]   y,
	input  logic [chacha20_pkg::WORD_W-1:0]   z,
	output logic [chacha20_pkg::WORD_W-1:0]   sum,
	output logic [chacha20_pkg::WORD_W-1:0]   mix
);

	logic [chacha20_pkg::WORD_W-1:0] t;

	assign sum = x + y;
	assign t   = z ^ sum;

	always_comb begin
		unique case (step)
			chacha20_pkg::STEP_AB16: mix = {t[15:0], t[31:16]};
			chacha20_pkg::STEP_CD12: mix = {t[19:0], t[31:20]};
			chacha20_pkg::STEP_AB8:  mix = {t[23:0], t[31:24]};
			chacha20_pkg::STEP_CD7:  mix = {t[24:0], t[31:25]};
			default:                 mix = t;
		endcase
	end

endmodule

[src/chacha20_cfg.sv]
// Key / nonce register bank on the APB-style port.
module chacha20_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [chacha20_pkg::ADDR_W-1:0]    paddr,
	input  logic [chacha20_pkg::REG_W-1:0]     pwdata,
	output logic [chacha20_pkg::REG_W-1:0]     prdata,
	output logic                               pready,
	output logic [3:0][chacha20_pkg::REG_W-1:0] key,
	output logic [chacha20_pkg::REG_W-1:0]     nonce
);

	logic [3:0][chacha20_pkg::REG_W-1:0]   key_q;
	logic [chacha20_pkg::REG_W-1:0]        nonce_q;
	logic [chacha20_pkg::REG_IDX_W-1:0]    idx;
	logic                                  wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[chacha20_pkg::ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				chacha20_pkg::REG_KEY0:  key_q[0] <= pwdata;
				chacha20_pkg::REG_KEY1:  key_q[1] <= pwdata;
				chacha20_pkg::REG_KEY2:  key_q[2] <= pwdata;
				chacha20_pkg::REG_KEY3:  key_q[3] <= pwdata;
				chacha20_pkg::REG_NONCE: nonce_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			chacha20_pkg::REG_KEY0:  prdata = key_q[0];
			chacha20_pkg::REG_KEY1:  prdata = key_q[1];
			chacha20_pkg::REG_KEY2:  prdata = key_q[2];
			chacha20_pkg::REG_KEY3:  prdata = key_q[3];
			chacha20_pkg::REG_NONCE: prdata = nonce_q;
			default:                 prdata = '0;
		endcase
	end

	assign key   = key_q;
	assign nonce = nonce_q;

endmodule

[src/chacha20_seq.sv]
// Sequencer: quarter-round steps, column/diagonal phases, double rounds,
// then the sixteen feed-forward adds, then the emit that waits for a free output.
module chacha20_seq #(
	parameter int ROUND_COUNT = chacha20_pkg::ROUND_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    out_free,
	output chacha20_pkg::seq_ctl_t  ctl
);

	localparam int DR_COUNT = (ROUND_COUNT + 1) / 2;
	localparam int DR_W     = (DR_COUNT > 1) ? $clog2(DR_COUNT) : 1;

	chacha20_pkg::state_t state_q, state_nxt;
	logic [1:0]      step_q;
	logic [1:0]      qr_q;
	logic            diag_q;
	logic [DR_W-1:0] dr_q;
	logic [3:0]      add_q;
	logic            round_done;

	assign round_done = (step_q == chacha20_pkg::STEP_CD7) && (qr_q == 2'd3) && diag_q
		&& (dr_q == DR_W'(DR_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chacha20_pkg::ST_IDLE;
			step_q  <= '0;
			qr_q    <= '0;
			diag_q  <= 1'b0;
			dr_q    <= '0;
			add_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				step_q <= '0;
				qr_q   <= '0;
				diag_q <= 1'b0;
				dr_q   <= '0;
				add_q  <= '0;
			end else if (state_q == chacha20_pkg::ST_ROUND) begin
				step_q <= step_q + 2'd1;
				if (step_q == chacha20_pkg::STEP_CD7) begin
					qr_q <= qr_q + 2'd1;
					if (qr_q == 2'd3) begin
						diag_q <= ~diag_q;
						if (diag_q)
							dr_q <= round_done ? '0 : dr_q + DR_W'(1);
					end
				end
			end else if (state_q == chacha20_pkg::ST_ADD) begin
				add_q <= add_q + 4'd1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			chacha20_pkg::ST_IDLE:  if (start) state_nxt = chacha20_pkg::ST_ROUND;
			chacha20_pkg::ST_ROUND: if (round_done) state_nxt = chacha20_pkg::ST_ADD;
			chacha20_pkg::ST_ADD:   if (add_q == 4'd15) state_nxt = chacha20_pkg::ST_EMIT;
			chacha20_pkg::ST_EMIT:  if (out_free) state_nxt = chacha20_pkg::ST_IDLE;
			default:                state_nxt = chacha20_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.idle     = (state_q == chacha20_pkg::ST_IDLE);
		ctl.round_en = (state_q == chacha20_pkg::ST_ROUND);
		ctl.step     = step_q;
		ctl.diag     = diag_q;
		ctl.last_qr  = (qr_q == 2'd3);
		ctl.add_en   = (state_q == chacha20_pkg::ST_ADD);
		ctl.add_last = (state_q == chacha20_pkg::ST_ADD) && (add_q == 4'd15);
		ctl.add_idx  = add_q;
		ctl.emit     = (state_q == chacha20_pkg::ST_EMIT);
	end

	a_add_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chacha20_pkg::ST_ADD) |-> (step_q == '0 && qr_q == '0 && !diag_q))
		else $error("round counters not wrapped in add phase");

	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chacha20_pkg::ST_ROUND && round_done) |=>
		(state_q == chacha20_pkg::ST_ADD && add_q == '0 && dr_q == '0))
		else $error("bad entry into add phase");

endmodule

[tb/chacha20_stream_cipher_tb.sv]
module chacha20_stream_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUNDS = chacha20_pkg::ROUND_COUNT_DEF;
	// cycles from accepting a block-start byte to its result with the output open
	localparam int BLOCK_LAT = 32 * ((ROUNDS + 1) / 2) + 17;
	// several times the slowest legal run (every byte starting a block, full stalls)
	localparam longint TIMEOUT_NS = 64'd50_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 185;

	// "expand 32-byte k" as little-endian words
	localparam logic [chacha20_pkg::WORD_W-1:0] EXPAND_W0 = 32'h6170_7865;
	localparam logic [chacha20_pkg::WORD_W-1:0] EXPAND_W1 = 32'h3320_646e;
	localparam logic [chacha20_pkg::WORD_W-1:0] EXPAND_W2 = 32'h7962_2d32;
	localparam logic [chacha20_pkg::WORD_W-1:0] EXPAND_W3 = 32'h6b20_6574;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		logic [chacha20_pkg::BYTE_W-1:0] data;
		logic                            last;
	} out_byte_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [chacha20_pkg::ADDR_W-1:0]     paddr;
	logic [chacha20_pkg::REG_W-1:0]      pwdata;
	logic [chacha20_pkg::REG_W-1:0]      prdata;
	logic                                pready;
	logic                                in_valid;
	logic                                in_stall;
	logic [chacha20_pkg::BYTE_W-1:0]     data_in;
	logic                                first_byte;
	logic                                last_byte;
	logic                                out_valid;
	logic                                out_stall;
	logic [chacha20_pkg::BYTE_W-1:0]     data_out;
	logic                                last_out;

	// cipher model state
	logic [chacha20_pkg::REG_W-1:0]      key_reg [4];
	logic [chacha20_pkg::REG_W-1:0]      nonce_reg;
	logic [63:0]                         blk_ctr;
	logic [5:0]                          byte_pos;
	logic [chacha20_pkg::WORD_W-1:0]     ks_words [chacha20_pkg::WORD_CNT];
	logic [chacha20_pkg::WORD_W-1:0]     mix_w [chacha20_pkg::WORD_CNT];

	out_byte_t            pending_bytes [$];
	int                   err_count = 0;
	int                   items_sent = 0;
	int                   burst_left = 0;
	bit                   gaps_enabled = 1'b1;
	int                   hold_cycles = 0;
	bit                   holding = 1'b0;

	chacha20_stream_cipher #(
		.ROUND_COUNT(ROUNDS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_in    (data_in),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.last_out   (last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- cipher model

	function automatic logic [chacha20_pkg::WORD_W-1:0] rotl32(
			input logic [chacha20_pkg::WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_mix(input int a, input int b, input int c, input int d);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
		mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
		mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
	endfunction

	// builds the next 64-byte keystream block from the current key/nonce/counter
	function automatic void refill_keystream();
		logic [chacha20_pkg::WORD_W-1:0] seed_w [chacha20_pkg::WORD_CNT];
		int r;
		seed_w[0] = EXPAND_W0;
		seed_w[1] = EXPAND_W1;
		seed_w[2] = EXPAND_W2;
		seed_w[3] = EXPAND_W3;
		for (int i = 0; i < 4; i++) begin
			seed_w[4 + 2 * i] = key_reg[i][31:0];
			seed_w[5 + 2 * i] = key_reg[i][63:32];
		end
		seed_w[12] = blk_ctr[31:0];
		seed_w[13] = blk_ctr[63:32];
		seed_w[14] = nonce_reg[31:0];
		seed_w[15] = nonce_reg[63:32];
		for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
			mix_w[i] = seed_w[i];
		// rounds go in column/diagonal pairs, so an odd count rounds up
		for (r = 0; r < ROUNDS; r += 2) begin
			quarter_mix(0, 4, 8, 12);
			quarter_mix(1, 5, 9, 13);
			quarter_mix(2, 6, 10, 14);
			quarter_mix(3, 7, 11, 15);
			quarter_mix(0, 5, 10, 15);
			quarter_mix(1, 6, 11, 12);
			quarter_mix(2, 7, 8, 13);
			quarter_mix(3, 4, 9, 14);
		end
		for (int i = 0; i < chacha20_pkg::WORD_CNT; i++)
			ks_words[i] = mix_w[i] + seed_w[i];
	endfunction

	function automatic out_byte_t cipher_byte(input logic [chacha20_pkg::BYTE_W-1:0] d,
			input logic first, input logic last);
		out_byte_t res;
		logic [chacha20_pkg::WORD_W-1:0] w;
		if (first) begin
			blk_ctr = '0;
			byte_pos = '0;
		end
		if (byte_pos == 6'd0) begin
			refill_keystream();
			blk_ctr = blk_ctr + 64'd1;      // wraps naturally at all ones
		end
		w = ks_words[byte_pos[5:2]];
		res.data = d ^ w[8 * byte_pos[1:0] +: 8];
		res.last = last;
		// a last byte throws away the rest of the block
		byte_pos = last ? 6'd0 : byte_pos + 6'd1;
		return res;
	endfunction

	function automatic logic [chacha20_pkg::REG_W-1:0] reg_model(
			input logic [chacha20_pkg::REG_IDX_W-1:0] idx);
		unique case (idx)
			chacha20_pkg::REG_KEY0:  return key_reg[0];
			chacha20_pkg::REG_KEY1:  return key_reg[1];
			chacha20_pkg::REG_KEY2:  return key_reg[2];
			chacha20_pkg::REG_KEY3:  return key_reg[3];
			chacha20_pkg::REG_NONCE: return nonce_reg;
			default:                 return '0;
		endcase
	endfunction

	function automatic void note_mismatch(input string what,
			input logic [chacha20_pkg::REG_W-1:0] exp_v,
			input logic [chacha20_pkg::REG_W-1:0] got_v);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, got_v);
	endfunction

	// ---------------------------------------------------------------- output side

	always @(posedge clk) begin : check_out
		out_byte_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: output transaction %0h with nothing pending", $realtime,
						data_out);
			end else begin
				exp_b = pending_bytes.pop_front();
				if (data_out !== exp_b.data)
					note_mismatch("data_out", exp_b.data, data_out);
				if (last_out !== exp_b.last)
					note_mismatch("last_out", exp_b.last, last_out);
			end
		end
	end

	// Receiver stall pattern. A nonzero hold_cycles request turns into a solid
	// hold-off of that many cycles once the current stretch ends.
	initial begin : stall_gen
		stall_mode_t mode;
		int len;
		int k;
		forever begin
			if (hold_cycles > 0) begin
				k = hold_cycles;
				hold_cycles = 0;
				holding = 1'b1;
				repeat (k) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				holding = 1'b0;
			end else begin
				mode = stall_mode_t'($urandom_range(0, 3));
				len = $urandom_range(4, 48);
				repeat (len) begin
					unique case (mode)
						STALL_NONE:  out_stall <= 1'b0;
						STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
						STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
						default:     out_stall <= ($urandom_range(0, 4) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// ---------------------------------------------------------------- input side

	// One byte transaction; the expected byte is queued when it is accepted.
	task automatic send_byte(input logic [chacha20_pkg::BYTE_W-1:0] d, input logic first,
			input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = gaps_enabled ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		data_in    <= d;
		first_byte <= first;
		last_byte  <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_bytes.push_back(cipher_byte(d, first, last));
		items_sent++;
	endtask

	task automatic send_message(input int len, input bit with_first, input bit with_last);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), with_first && (i == 0), with_last && (i == len - 1));
	endtask

	// Pauses the input until every queued byte has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_bytes.size() != 0);
	endtask

	task automatic write_reg(input logic [chacha20_pkg::REG_IDX_W-1:0] idx,
			input logic [chacha20_pkg::REG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		unique case (idx)
			chacha20_pkg::REG_KEY0:  key_reg[0] = val;
			chacha20_pkg::REG_KEY1:  key_reg[1] = val;
			chacha20_pkg::REG_KEY2:  key_reg[2] = val;
			chacha20_pkg::REG_KEY3:  key_reg[3] = val;
			chacha20_pkg::REG_NONCE: nonce_reg = val;
			default: ;      // unmapped index, write dropped
		endcase
		@(posedge clk);
	endtask

	task automatic read_check(input logic [chacha20_pkg::REG_IDX_W-1:0] idx);
		logic [chacha20_pkg::REG_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== reg_model(idx))
			note_mismatch("prdata", reg_model(idx), got);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// Reset values, then writes to the unmapped indexes must not disturb anything.
	task automatic test_register_access();
		logic [chacha20_pkg::REG_IDX_W-1:0] ri;
		for (ri = chacha20_pkg::REG_KEY0; ri <= chacha20_pkg::REG_NONCE; ri++)
			read_check(ri);
		// indexes above the nonce up to the top of the address range
		for (ri = chacha20_pkg::REG_NONCE + 3'd1; ri != chacha20_pkg::REG_KEY0; ri++)
			write_reg(ri, '1);
		for (ri = chacha20_pkg::REG_KEY0; ri <= chacha20_pkg::REG_NONCE; ri++)
			read_check(ri);
	endtask

	// Hand-picked bytes under the all-zero key: flag combinations, data extremes,
	// a restart inside a message, and a key change in the middle of a message.
	task automatic test_directed_vectors();
		// one-byte messages
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hff, 1'b1, 1'b1);
		// first restarts counter and position even mid-message
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b1, 1'b0);
		send_byte(8'h3c, 1'b0, 1'b0);
		send_byte(8'hc3, 1'b0, 1'b1);
		// no first flag: counter keeps running into a fresh block
		send_byte(8'h81, 1'b0, 1'b1);
		send_byte(8'h7e, 1'b0, 1'b0);
		send_byte(8'h18, 1'b0, 1'b1);
		// key change mid-message: current block keeps the old key
		send_byte(8'h11, 1'b1, 1'b0);
		send_byte(8'h22, 1'b0, 1'b0);
		drain_results();
		write_reg(chacha20_pkg::REG_KEY1, {$urandom, $urandom});
		send_byte(8'h33, 1'b0, 1'b0);
		send_byte(8'h44, 1'b0, 1'b1);
		send_byte(8'h55, 1'b1, 1'b1);
		drain_results();
	endtask

	// Every register at all ones, alternating bits, and back to zero.
	task automatic test_extreme_config();
		logic [chacha20_pkg::REG_W-1:0] pats [3];
		logic [chacha20_pkg::REG_IDX_W-1:0] ri;
		pats[0] = '1;
		pats[1] = 64'haaaa_aaaa_5555_5555;
		pats[2] = '0;
		for (int p = 0; p < 3; p++) begin
			drain_results();
			for (ri = chacha20_pkg::REG_KEY0; ri <= chacha20_pkg::REG_NONCE; ri++)
				write_reg(ri, pats[p]);
			for (ri = chacha20_pkg::REG_KEY0; ri <= chacha20_pkg::REG_NONCE; ri++)
				read_check(ri);
			send_message(4, 1'b1, 1'b1);
		end
		drain_results();
	endtask

	// Receiver holds off for a long stretch while bytes keep coming back-to-back,
	// so the block must stall its input until the output opens again.
	task automatic test_output_backpressure();
		gaps_enabled = 1'b0;
		burst_left = 0;
		hold_cycles = 3 * BLOCK_LAT;
		while (!holding) @(posedge clk);
		send_message(40, 1'b1, 1'b1);
		gaps_enabled = 1'b1;
		drain_results();
	endtask

	// Phases of random traffic, each under a new key/nonce mix. Mostly well-formed
	// messages (some spanning several blocks), plus continuations without a first
	// flag and short bursts with random flags.
	task automatic test_random_traffic();
		logic [chacha20_pkg::REG_IDX_W-1:0] ri;
		int target;
		int kind;
		int len;
		int pick;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			for (ri = chacha20_pkg::REG_KEY0; ri <= chacha20_pkg::REG_NONCE; ri++) begin
				pick = $urandom_range(0, 5);
				if (pick == 0)
					write_reg(ri, '0);
				else if (pick == 1)
					write_reg(ri, '1);
				else if (pick != 5)
					write_reg(ri, {$urandom, $urandom});
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(chacha20_pkg::REG_NONCE + 1, 7)),
					{$urandom, $urandom});
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), 1'($urandom), 1'($urandom));
				end else begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 200)
						: $urandom_range(1, 64);
					send_message(len, kind != 1, $urandom_range(0, 5) != 0);
				end
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_in    <= '0;
		first_byte <= 1'b0;
		last_byte  <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_reg = '0;
		blk_ctr = '0;
		byte_pos = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_vectors();
		test_extreme_config();
		test_output_backpressure();
		test_random_traffic();

		drain_results();
		// catch any stray output transaction after the last expected one
		repeat (BLOCK_LAT) @(posedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
